// File: rtl/core/ptzd_pkg.sv
`default_nettype none

package ptzd_pkg;

    // Message geometry.
    localparam int MSG_BYTES   = 10;
    localparam int BYTE_W      = 8;
    localparam int MSG_BITS    = MSG_BYTES * BYTE_W;
    localparam int COUNT_W     = 4;
    localparam int SPEED_W     = 11;

    // Defaults for the top-level parameters.
    localparam int MAX_SPEED_DEF   = 2047;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Byte values and message lengths.
    localparam logic [BYTE_W-1:0]  START_FLAG   = 8'h80;
    localparam logic [COUNT_W-1:0] LEN_STATUS   = 4'd2;
    localparam logic [COUNT_W-1:0] LEN_COMMAND  = 4'd6;
    localparam logic [COUNT_W-1:0] LEN_EXTENDED = 4'd10;

    // Direction codes for pan and tilt.
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_NEG  = 2'd1;
    localparam logic [1:0] DIR_POS  = 2'd2;

    // Lens pair codes.
    localparam logic [1:0] LENS_NONE   = 2'd0;
    localparam logic [1:0] LENS_FIRST  = 2'd1;
    localparam logic [1:0] LENS_SECOND = 2'd2;

    // Preset action codes.
    localparam logic [1:0] PRESET_NONE   = 2'd0;
    localparam logic [1:0] PRESET_RECALL = 2'd1;
    localparam logic [1:0] PRESET_STORE  = 2'd2;

    // Result kinds as seen on the msg_kind port.
    typedef enum logic [2:0] {
        KIND_STATUS     = 3'd0,
        KIND_COMMAND    = 3'd1,
        KIND_EXT_SPEED  = 3'd2,
        KIND_EXT_PRESET = 3'd3,
        KIND_EXT_STATUS = 3'd4,
        KIND_DROPPED    = 3'd5
    } msg_kind_t;

    // What the front end found when it closed a word.
    typedef enum logic [1:0] {
        FR_DROPPED  = 2'd0,
        FR_STATUS   = 2'd1,
        FR_COMMAND  = 2'd2,
        FR_EXTENDED = 2'd3
    } frame_class_t;

    // One word passed from the front end to the back end.
    typedef struct packed {
        frame_class_t                       cls;
        logic [MSG_BYTES-1:0][BYTE_W-1:0]   bytes;
    } frame_t;

    // One decoded result.
    typedef struct packed {
        msg_kind_t          kind;
        logic [7:0]         receiver;
        logic [1:0]         pan_dir;
        logic [SPEED_W-1:0] pan_speed;
        logic [1:0]         tilt_dir;
        logic [SPEED_W-1:0] tilt_speed;
        logic [5:0]         lens_cmd;
        logic [3:0]         toggle_flags;
        logic [5:0]         aux_flags;
        logic [1:0]         preset_action;
        logic [6:0]         preset_number;
        logic [2:0]         status_flags;
    } result_t;

    // Pick one of two exclusive bits; the first one wins.
    function automatic logic [1:0] pick2(input logic first_bit, input logic second_bit);
        logic [1:0] code;
        if (first_bit) begin
            code = LENS_FIRST;
        end else if (second_bit) begin
            code = LENS_SECOND;
        end else begin
            code = LENS_NONE;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ptz_serial_message_decoder.sv
`default_nettype none

// Channel   Handshake         Moves        Fields
// -------   ---------------   ----------   ----------------------------------------------
// input     push / full       one byte     rx_byte
// result    empty / pop       one result   msg_kind, receiver, pan/tilt, lens, flags,
//                                          preset_action, preset_number, status_flags
//
// One byte is taken every cycle while full is low; the front counter gathers bytes
// and closes a word on the last byte of a message or on a dropped byte.
// A result reaches the ports through the queue entry, written on the edge that takes its
// closing byte, and then the decode output register, which loads once it is free or popped.
// Results can leave one per cycle while pop is high and words are waiting in the queue.
// Reset clears the byte counter, the queue and the output valid flag at once.
// Full rises only when the queue is full and the output register is held by pop low.

module ptz_serial_message_decoder
    import ptzd_pkg::*;
#(
    parameter int MAX_SPEED   = MAX_SPEED_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [BYTE_W-1:0]  rx_byte,
    output logic                    empty,
    input  wire logic               pop,
    output logic [2:0]              msg_kind,
    output logic [7:0]              receiver,
    output logic [1:0]              pan_dir,
    output logic [SPEED_W-1:0]      pan_speed,
    output logic [1:0]              tilt_dir,
    output logic [SPEED_W-1:0]      tilt_speed,
    output logic [5:0]              lens_cmd,
    output logic [3:0]              toggle_flags,
    output logic [5:0]              aux_flags,
    output logic [1:0]              preset_action,
    output logic [6:0]              preset_number,
    output logic [2:0]              status_flags
);

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    frame_t  q_in;
    frame_t  q_head;
    result_t result;

    assign full = q_full;

    // Byte gathering and message classification.
    ptzd_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rx_byte (rx_byte),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_frame (q_in)
    );

    // Word queue between the two halves.
    ptzd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_frame (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    // Field decode and result register.
    ptzd_back #(
        .MAX_SPEED (MAX_SPEED)
    ) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // Result fields to their ports.
    assign msg_kind      = result.kind;
    assign receiver      = result.receiver;
    assign pan_dir       = result.pan_dir;
    assign pan_speed     = result.pan_speed;
    assign tilt_dir      = result.tilt_dir;
    assign tilt_speed    = result.tilt_speed;
    assign lens_cmd      = result.lens_cmd;
    assign toggle_flags  = result.toggle_flags;
    assign aux_flags     = result.aux_flags;
    assign preset_action = result.preset_action;
    assign preset_number = result.preset_number;
    assign status_flags  = result.status_flags;

endmodule

`default_nettype wire

// File: rtl/core/ptzd_front.sv
`default_nettype none

module ptzd_front
    import ptzd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              q_full,
    output logic                   q_push,
    output frame_t                 q_frame
);

    logic [COUNT_W-1:0]               byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0]               msg_length_reg, msg_length_next;
    logic [MSG_BYTES-1:0][BYTE_W-1:0] bytes_reg;

    logic               accept;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] len_new;
    logic [COUNT_W-1:0] len_eff;

    assign accept    = push && !q_full;
    assign count_inc = byte_count_reg + COUNT_W'(1);

    // Byte 1 settles the length: bit 4 marks a command, bit 6 an extended one.
    assign len_new = rx_byte[4] ? (rx_byte[6] ? LEN_EXTENDED : LEN_COMMAND) : LEN_STATUS;
    assign len_eff = (count_inc == COUNT_W'(2)) ? len_new : msg_length_reg;

    // Counting, classifying and building the outgoing word.
    always_comb
    begin
        byte_count_next = byte_count_reg;
        msg_length_next = msg_length_reg;
        q_push          = 1'b0;
        q_frame.bytes   = bytes_reg;
        q_frame.bytes[byte_count_reg] = rx_byte;
        q_frame.cls     = FR_DROPPED;
        if (accept) begin
            if (byte_count_reg == '0) begin
                if ((rx_byte & START_FLAG) == '0) begin
                    q_push = 1'b1;
                end else begin
                    byte_count_next = COUNT_W'(1);
                    msg_length_next = '0;
                end
            end else if (count_inc >= len_eff) begin
                q_push          = 1'b1;
                byte_count_next = '0;
                msg_length_next = '0;
                if (len_eff == LEN_STATUS) begin
                    q_frame.cls = FR_STATUS;
                end else if (len_eff == LEN_COMMAND) begin
                    q_frame.cls = FR_COMMAND;
                end else begin
                    q_frame.cls = FR_EXTENDED;
                end
            end else begin
                byte_count_next = count_inc;
                msg_length_next = len_eff;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_count_reg <= '0;
            msg_length_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            msg_length_reg <= msg_length_next;
        end
    end

    // Gathered bytes; each accepted byte lands at the current count.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            bytes_reg[byte_count_reg] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ptzd_queue.sv
`default_nettype none

module ptzd_queue
    import ptzd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire frame_t push_frame,
    output logic        full,
    input  wire logic   pop,
    output logic        valid,
    output frame_t      head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign head    = entries_reg[rd_ptr_reg];

    // Pointer and fill-level updates with wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ptzd_back.sv
`default_nettype none

module ptzd_back
    import ptzd_pkg::*;
#(
    parameter int MAX_SPEED = MAX_SPEED_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    input  wire frame_t q_head,
    output logic        q_pop,
    input  wire logic   pop,
    output logic        empty,
    output result_t     result
);

    localparam logic [SPEED_W-1:0] SPEED_FULL = SPEED_W'(MAX_SPEED);

    logic                             out_valid_reg, out_valid_next;
    result_t                          out_reg;
    result_t                          dec;
    logic [MSG_BITS-1:0]              m;
    logic [MSG_BYTES-1:0][BYTE_W-1:0] b;

    assign b = q_head.bytes;
    assign m = q_head.bytes;

    // Field extraction for the word at the head of the queue.
    always_comb
    begin
        dec          = '0;
        dec.receiver = {b[0][3:0], b[1][3:0]};
        unique case (q_head.cls)
            FR_DROPPED:
            begin
                dec      = '0;
                dec.kind = KIND_DROPPED;
            end
            FR_STATUS:
            begin
                dec.kind = KIND_STATUS;
            end
            FR_COMMAND, FR_EXTENDED:
            begin
                dec.kind = (q_head.cls == FR_EXTENDED) ? KIND_EXT_SPEED : KIND_COMMAND;

                // Pan: right beats left; no bit means left at zero speed.
                if (m[21]) begin
                    dec.pan_dir   = DIR_POS;
                    dec.pan_speed = SPEED_FULL;
                end else if (m[22]) begin
                    dec.pan_dir   = DIR_NEG;
                    dec.pan_speed = SPEED_FULL;
                end else begin
                    dec.pan_dir   = DIR_NEG;
                    dec.pan_speed = '0;
                end

                // Tilt: up beats down.
                if (m[20]) begin
                    dec.tilt_dir   = DIR_POS;
                    dec.tilt_speed = SPEED_FULL;
                end else if (m[19]) begin
                    dec.tilt_dir   = DIR_NEG;
                    dec.tilt_speed = SPEED_FULL;
                end else begin
                    dec.tilt_dir   = DIR_NEG;
                    dec.tilt_speed = '0;
                end

                dec.lens_cmd     = {pick2(m[29], m[30]), pick2(m[27], m[28]),
                                    pick2(m[26], m[25])};
                dec.toggle_flags = {m[24], m[18], m[17], m[13]};
                dec.aux_flags    = {m[33], m[34], m[35], m[36], m[37], m[38]};

                // Preset in the command bytes; recall wins over store.
                if (m[45] || m[46]) begin
                    dec.preset_action = m[45] ? PRESET_RECALL : PRESET_STORE;
                    dec.preset_number = {3'b000, b[5][3:0]};
                    dec.pan_dir       = DIR_NONE;
                    dec.tilt_dir      = DIR_NONE;
                    dec.toggle_flags  = '0;
                end

                // Extended part of a ten-byte message.
                if (q_head.cls == FR_EXTENDED) begin
                    if (m[52]) begin
                        if (m[49]) begin
                            dec.kind         = KIND_EXT_STATUS;
                            dec.status_flags = {m[48] && m[58], m[57], m[56]};
                        end else begin
                            dec.kind          = KIND_EXT_PRESET;
                            dec.preset_action = m[48] ? PRESET_STORE : PRESET_RECALL;
                            dec.preset_number = b[7][6:0];
                            dec.pan_dir       = DIR_NONE;
                            dec.tilt_dir      = DIR_NONE;
                            dec.toggle_flags  = '0;
                            dec.pan_speed     = {4'b0000, b[8][6:0]};
                            dec.tilt_speed    = {4'b0000, b[9][6:0]};
                        end
                    end else begin
                        dec.pan_speed  = {b[6][3:0], b[7][6:0]};
                        dec.tilt_speed = {b[8][3:0], b[9][6:0]};
                    end
                end
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

    // The output register loads whenever the queue holds a word and the register is free or being drained.
    assign q_pop  = q_valid && (!out_valid_reg || pop);
    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            out_reg <= dec;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ptzd_checker.sv
`default_nettype none

module ptzd_checker
    import ptzd_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic [2:0]        msg_kind,
    input wire logic [7:0]        receiver,
    input wire logic [1:0]        pan_dir,
    input wire logic [SPEED_W-1:0] pan_speed,
    input wire logic [1:0]        tilt_dir,
    input wire logic [SPEED_W-1:0] tilt_speed,
    input wire logic [5:0]        lens_cmd,
    input wire logic [3:0]        toggle_flags,
    input wire logic [5:0]        aux_flags,
    input wire logic [1:0]        preset_action,
    input wire logic [6:0]        preset_number,
    input wire logic [2:0]        status_flags
);

    // A waiting word that is not taken stays as it is.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(msg_kind) && $stable(receiver)
                              && $stable(pan_speed) && $stable(preset_number)))
        else $error("held result word changed");

    // A dropped byte carries nothing but its kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && msg_kind == KIND_DROPPED) |-> (receiver == '0 && pan_speed == '0
            && tilt_speed == '0 && lens_cmd == '0 && aux_flags == '0
            && preset_action == PRESET_NONE && status_flags == '0))
        else $error("dropped byte word has nonzero fields");

    // A status request decodes only the receiver address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && msg_kind == KIND_STATUS) |-> (pan_dir == DIR_NONE
            && tilt_dir == DIR_NONE && pan_speed == '0 && tilt_speed == '0
            && preset_action == PRESET_NONE && status_flags == '0))
        else $error("status request word has command fields");

    // A preset action clears both directions and the toggles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && preset_action != PRESET_NONE) |-> (pan_dir == DIR_NONE
            && tilt_dir == DIR_NONE && toggle_flags == '0))
        else $error("preset word keeps direction or toggles");

    // The input side only backs up behind a result that is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full while no result word is waiting");

endmodule

bind ptz_serial_message_decoder ptzd_checker u_ptzd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .msg_kind      (msg_kind),
    .receiver      (receiver),
    .pan_dir       (pan_dir),
    .pan_speed     (pan_speed),
    .tilt_dir      (tilt_dir),
    .tilt_speed    (tilt_speed),
    .lens_cmd      (lens_cmd),
    .toggle_flags  (toggle_flags),
    .aux_flags     (aux_flags),
    .preset_action (preset_action),
    .preset_number (preset_number),
    .status_flags  (status_flags)
);

`default_nettype wire
